// ----- rtl/picp_pkg.sv -----
// ----------------------------------------------------------------------------
// picp_pkg
// Shared widths and transaction types for the perspective-correct interpolator.
// ----------------------------------------------------------------------------
package picp_pkg;

    // Default and widest attribute width
    localparam int VALUE_BITS_DEF = 24;
    localparam int VALUE_BITS_MAX = 32;

    // Divider widths, sized for the widest attribute
    // numerator: |value diff| (32 bits) times |position| (11 bits)
    localparam int NUM_W = 43;
    // denominator: sum of two 12 x 17 bit products, magnitude below 2^28
    localparam int DEN_W = 28;

    // Perspective factor fraction widths
    localparam int SHIFT_NINE  = 9;
    localparam int SHIFT_EIGHT = 8;

    // Weight masks
    localparam logic [15:0] W_MID_MASK = 16'h007E;
    localparam logic [15:0] W_LSB_CLR  = 16'hFFFE;

    // Information that travels alongside the quotient
    typedef struct packed {
        logic        lin;   // linear or pass-through result
        logic        nine;  // 9-bit factor precision
        logic        up;    // value_start < value_end
        logic        neg;   // quotient is negative
        logic [31:0] base;  // value added to the scaled term
        logic [31:0] diff;  // magnitude of the value difference
    } side_t;

    // Data passed from cell to cell in the divider chain
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;   // numerator bits out, quotient bits in
        side_t            side;
    } div_t;

endpackage

// ----- rtl/picp_front.sv -----
// ----------------------------------------------------------------------------
// picp_front
// Two-stage set-up: forms weights and products, then the divider operands.
// ----------------------------------------------------------------------------
module picp_front #(
    parameter int VALUE_BITS = picp_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         precision_nine,
    input  logic signed [10:0]           span_start,
    input  logic signed [10:0]           span_end,
    input  logic        [15:0]           weight_start,
    input  logic        [15:0]           weight_end,
    input  logic signed [10:0]           sample_pos,
    input  logic signed [VALUE_BITS-1:0] value_start,
    input  logic signed [VALUE_BITS-1:0] value_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output picp_pkg::div_t               out_data
);

    // Stage one combinational terms
    logic signed [11:0] rel, len, r2, tv;
    logic        [10:0] tabs;
    logic signed [32:0] y0e, y1e;
    logic               up, triv, lin;
    logic        [32:0] diff_c;
    logic        [15:0] wn;
    logic        [16:0] wd0, wd1;

    always_comb begin
        rel  = 12'(sample_pos) - 12'(span_start);
        len  = 12'(span_end) - 12'(span_start);
        r2   = 12'(span_end) - 12'(sample_pos);
        y0e  = 33'(value_start);
        y1e  = 33'(value_end);
        up   = y0e < y1e;
        triv = (len == 12'sd0) || (y0e == y1e);
        lin  = (weight_start == weight_end) &&
               ((weight_start & picp_pkg::W_MID_MASK) == 16'h0000);
        diff_c = up ? 33'(y1e - y0e) : 33'(y0e - y1e);
        tv   = up ? rel : r2;
        tabs = tv[11] ? 11'(-tv) : tv[10:0];
        // weight adjustment for 9-bit precision
        if (precision_nine) begin
            if (weight_start[0] && !weight_end[0]) begin
                wn  = weight_start - 16'd1;
                wd0 = 17'(weight_start) + 17'd1;
                wd1 = 17'(weight_end);
            end else begin
                wn  = weight_start & picp_pkg::W_LSB_CLR;
                wd0 = 17'(weight_start & picp_pkg::W_LSB_CLR);
                wd1 = 17'(weight_end & picp_pkg::W_LSB_CLR);
            end
        end else begin
            wn  = weight_start;
            wd0 = 17'(weight_start);
            wd1 = 17'(weight_end);
        end
    end

    // Stage one registers
    logic                         v1_reg;
    logic                         nine1_reg, lin1_reg, triv1_reg, up1_reg, tneg1_reg;
    logic        [31:0]           base1_reg, diff1_reg;
    logic signed [11:0]           len1_reg;
    logic signed [29:0]           pn1_reg, pa1_reg, pb1_reg;
    logic        [picp_pkg::NUM_W-1:0] pt1_reg;
    logic                         rdy1;

    assign in_ready = !v1_reg || rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            nine1_reg <= precision_nine;
            lin1_reg  <= lin;
            triv1_reg <= triv;
            up1_reg   <= up;
            tneg1_reg <= tv[11];
            base1_reg <= triv ? y0e[31:0] : (up ? y0e[31:0] : y1e[31:0]);
            diff1_reg <= diff_c[31:0];
            len1_reg  <= len;
            pn1_reg   <= 30'(rel) * 30'($signed({1'b0, wn}));
            pa1_reg   <= 30'(rel) * 30'($signed({1'b0, wd0}));
            pb1_reg   <= 30'(r2) * 30'($signed({1'b0, wd1}));
            pt1_reg   <= picp_pkg::NUM_W'(diff_c[31:0]) * picp_pkg::NUM_W'(tabs);
        end
    end

    // Stage two: denominator sum and operand selection
    logic signed [30:0] den_c, dabs;
    logic signed [29:0] pabs;
    logic        [11:0] labs;
    picp_pkg::div_t     d_c;

    always_comb begin
        den_c = 31'(pa1_reg) + 31'(pb1_reg);
        dabs  = den_c[30] ? -den_c : den_c;
        pabs  = pn1_reg[29] ? -pn1_reg : pn1_reg;
        labs  = len1_reg[11] ? 12'(-len1_reg) : len1_reg;
        d_c.rem       = '0;
        d_c.side.lin  = lin1_reg || triv1_reg;
        d_c.side.nine = nine1_reg;
        d_c.side.up   = up1_reg;
        d_c.side.base = base1_reg;
        d_c.side.diff = diff1_reg;
        priority if (triv1_reg || (!lin1_reg && den_c == 31'sd0)) begin
            d_c.nq       = '0;
            d_c.den      = picp_pkg::DEN_W'(1);
            d_c.side.neg = 1'b0;
        end else if (lin1_reg) begin
            d_c.nq       = pt1_reg;
            d_c.den      = picp_pkg::DEN_W'(labs);
            d_c.side.neg = tneg1_reg ^ len1_reg[11];
        end else begin
            d_c.nq       = nine1_reg ?
                           (picp_pkg::NUM_W'(pabs[28:0]) << picp_pkg::SHIFT_NINE) :
                           (picp_pkg::NUM_W'(pabs[28:0]) << picp_pkg::SHIFT_EIGHT);
            d_c.den      = dabs[picp_pkg::DEN_W-1:0];
            d_c.side.neg = pn1_reg[29] ^ den_c[30];
        end
    end

    logic v2_reg;
    assign rdy1 = !v2_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy1) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && v1_reg) begin
            out_data <= d_c;
        end
    end

    assign out_valid = v2_reg;

endmodule

// ----- rtl/picp_div_cell.sv -----
// ----------------------------------------------------------------------------
// picp_div_cell
// One restoring division step: yields one quotient bit and hands on.
// ----------------------------------------------------------------------------
module picp_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  picp_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output picp_pkg::div_t out_data
);

    logic                    v_reg;
    logic [picp_pkg::DEN_W:0] shifted, trial;
    picp_pkg::div_t          d_next;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        shifted = {in_data.rem, in_data.nq[picp_pkg::NUM_W-1]};
        trial   = shifted - {1'b0, in_data.den};
        d_next  = in_data;
        if (!trial[picp_pkg::DEN_W]) begin
            d_next.rem = trial[picp_pkg::DEN_W-1:0];
            d_next.nq  = {in_data.nq[picp_pkg::NUM_W-2:0], 1'b1};
        end else begin
            d_next.rem = shifted[picp_pkg::DEN_W-1:0];
            d_next.nq  = {in_data.nq[picp_pkg::NUM_W-2:0], 1'b0};
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_data <= d_next;
        end
    end

    assign out_valid = v_reg;

endmodule

// ----- rtl/picp_back.sv -----
// ----------------------------------------------------------------------------
// picp_back
// Signs the quotient, applies the perspective factor and forms the result.
// ----------------------------------------------------------------------------
module picp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  picp_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    value_out
);

    // Stage one: signed factor and its complement
    logic [picp_pkg::NUM_W:0] f_c, one_c, g_c;

    always_comb begin
        f_c   = in_data.side.neg ? -{1'b0, in_data.nq} : {1'b0, in_data.nq};
        one_c = in_data.side.nine ? (44'd1 << picp_pkg::SHIFT_NINE) :
                                    (44'd1 << picp_pkg::SHIFT_EIGHT);
        g_c   = (in_data.side.lin || in_data.side.up) ? f_c : (one_c - f_c);
    end

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic [40:0] g1_reg;
    logic        lin1_reg, nine1_reg, lin2_reg, nine2_reg;
    logic [31:0] base1_reg, diff1_reg, base2_reg;
    logic [40:0] mlo2_reg;
    logic [19:0] mhi2_reg;
    logic [31:0] val3_reg;

    assign in_ready = !v1_reg || rdy1;
    assign rdy1     = !v2_reg || rdy2;
    assign rdy2     = !v3_reg || rdy3;
    assign rdy3     = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (rdy1) begin
                v2_reg <= v1_reg;
            end
            if (rdy2) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage one registers
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            g1_reg    <= g_c[40:0];
            lin1_reg  <= in_data.side.lin;
            nine1_reg <= in_data.side.nine;
            base1_reg <= in_data.side.base;
            diff1_reg <= in_data.side.diff;
        end
    end

    // Stage two: low 41 bits of diff * factor as two partial products, or the factor itself for linear results
    logic [52:0] mlo_c;
    logic [39:0] mhi_c;

    always_comb begin
        mlo_c = 53'(diff1_reg) * 53'(g1_reg[20:0]);
        mhi_c = 40'(diff1_reg[19:0]) * 40'(g1_reg[40:21]);
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && v1_reg) begin
            lin2_reg  <= lin1_reg;
            nine2_reg <= nine1_reg;
            base2_reg <= base1_reg;
            mlo2_reg  <= lin1_reg ? 41'(g1_reg[31:0]) : mlo_c[40:0];
            mhi2_reg  <= mhi_c[19:0];
        end
    end

    // Stage three: combine, scale down and add the base
    logic [40:0] p_c;
    logic [31:0] term_c;

    always_comb begin
        p_c = mlo2_reg + {mhi2_reg, 21'b0};
        if (lin2_reg) begin
            term_c = mlo2_reg[31:0];
        end else if (nine2_reg) begin
            term_c = p_c[picp_pkg::SHIFT_NINE+31:picp_pkg::SHIFT_NINE];
        end else begin
            term_c = p_c[picp_pkg::SHIFT_EIGHT+31:picp_pkg::SHIFT_EIGHT];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v2_reg) begin
            val3_reg <= base2_reg + term_c;
        end
    end

    assign out_valid = v3_reg;
    assign value_out = val3_reg;

endmodule

// ----- rtl/perspective_correct_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// perspective_correct_interpolator_core
// Perspective-correct attribute interpolator built as a pipeline around a
// chain of restoring divider cells.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | span, weights, sample, values
//   m_      | out       | m_valid / m_ready  | m_value_out
//
// One transaction is accepted per cycle while the output is not stalled; the path
// has two set-up stages, one divider cell per quotient bit and three output stages.
// The divider cell chain sets both the latency and the one-per-cycle rate.
// Reset is synchronous, active low, and empties every stage.
// Each stage holds its transaction while the next is full and stalled, so
// bubbles are squeezed out and input is taken while a result waits.
// ----------------------------------------------------------------------------
module perspective_correct_interpolator_core #(
    parameter int VALUE_BITS = picp_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_precision_nine,
    input  logic signed [10:0]           s_span_start,
    input  logic signed [10:0]           s_span_end,
    input  logic        [15:0]           s_weight_start,
    input  logic        [15:0]           s_weight_end,
    input  logic signed [10:0]           s_sample_pos,
    input  logic signed [VALUE_BITS-1:0] s_value_start,
    input  logic signed [VALUE_BITS-1:0] s_value_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_value_out
);

    localparam int CELLS = picp_pkg::NUM_W;

    logic           cv   [CELLS+1];
    logic           cr   [CELLS+1];
    picp_pkg::div_t cd   [CELLS+1];
    logic [31:0]    value_w;

    // Set-up stages
    picp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .precision_nine(s_precision_nine),
        .span_start    (s_span_start),
        .span_end      (s_span_end),
        .weight_start  (s_weight_start),
        .weight_end    (s_weight_end),
        .sample_pos    (s_sample_pos),
        .value_start   (s_value_start),
        .value_end     (s_value_end),
        .out_valid     (cv[0]),
        .out_ready     (cr[0]),
        .out_data      (cd[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        picp_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (cv[i]),
            .in_ready (cr[i]),
            .in_data  (cd[i]),
            .out_valid(cv[i+1]),
            .out_ready(cr[i+1]),
            .out_data (cd[i+1])
        );
    end

    // Output stages
    picp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cv[CELLS]),
        .in_ready (cr[CELLS]),
        .in_data  (cd[CELLS]),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .value_out(value_w)
    );

    assign m_value_out = $signed(value_w);

    // Checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    a_chain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cr[CELLS] |-> cr[0])
        else $error("divider chain stalled while its tail can advance");

endmodule
